/* hw/rtl/rdmd_pkg.sv */
`timescale 1ns / 1ps
package rdmd_pkg;
  localparam int unsigned MaxPixelsDefault = 16384;
  localparam int unsigned NumBinsDefault = 256;
  localparam int unsigned HistMax = 32767;
  localparam int unsigned BfWidth = 20;
  localparam int unsigned DispWidth = 16;
  localparam int unsigned DistWidth = 32;
  localparam int unsigned CfgIdxWidth = 2;
  localparam int unsigned CfgDataWidth = 32;
  localparam logic [CfgIdxWidth-1:0] RegBaselineFocal = 2'd0;
  localparam logic [CfgIdxWidth-1:0] RegInfinityDisparity = 2'd1;
  localparam logic [CfgIdxWidth-1:0] RegMinMeanDisparity = 2'd2;
  localparam logic [BfWidth-1:0] BfReset = 20'd28068;
  localparam logic [DispWidth-1:0] DinfReset = 16'd26;
  localparam logic [DispWidth-1:0] MinMeanReset = 16'd512;
  localparam logic [DispWidth-1:0] FoundThreshold = 16'd512;
endpackage

/* hw/rtl/roi_disparity_mode_distance.sv */
`timescale 1ns / 1ps
// Takes one disparity word per cycle into a pixel store and histogram until a word flagged
// last arrives. Then the block stops taking words while a sequencer clears-and-scans
// the histogram, computes the window half-width with a shared restoring divider (skipped
// when the divisor is not positive), walks the stored pixels (one per cycle), and runs
// two more divisions for the mean and distance (the distance one is skipped when its
// divisor is not positive); an empty histogram skips straight to the result. The
// histogram scan also returns every bin to zero for the next region.
// The histogram is cleared by a sweep after reset before the first word is accepted;
// configuration writes are taken at any time.
module roi_disparity_mode_distance #(
  parameter int unsigned MAX_PIXELS = rdmd_pkg::MaxPixelsDefault,
  parameter int unsigned NUM_BINS = rdmd_pkg::NumBinsDefault
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  logic [rdmd_pkg::DispWidth-1:0] disparity,
  input  logic last,
  output logic out_valid,
  input  logic out_stall,
  output logic [rdmd_pkg::DistWidth-1:0] distance,
  output logic [rdmd_pkg::DispWidth-1:0] mean_disparity,
  output logic found,
  output logic above_min,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [rdmd_pkg::CfgIdxWidth-1:0] cfg_index,
  input  logic [rdmd_pkg::CfgDataWidth-1:0] cfg_data
);
  import rdmd_pkg::*;

  localparam int unsigned AW = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
  localparam int unsigned CW = $clog2(MAX_PIXELS + 1);
  localparam int unsigned BW = $clog2(NUM_BINS);
  localparam int unsigned BCW = $clog2(NUM_BINS + 1);
  localparam int unsigned HW = 15;
  localparam int unsigned SW = CW + DispWidth;
  localparam int unsigned DW = 64;
  localparam int unsigned DCW = 7;

  typedef enum logic [3:0] {
    S_INIT, S_LOAD, S_SCAN, S_WDIV0, S_WDIV, S_WIN, S_MDIV, S_DDIV0, S_DDIV, S_OUT
  } state_t;

  state_t state;
  logic [BfWidth-1:0] bf;
  logic [DispWidth-1:0] dinf, min_mean;

  logic [DispWidth-1:0] store [MAX_PIXELS];
  logic [HW-1:0] hist [NUM_BINS];
  logic [DispWidth-1:0] store_q;
  logic [HW-1:0] hist_q;

  logic [CW-1:0] count;
  logic [BCW-1:0] bin_ptr;
  logic [BCW-1:0] scan_lag;
  logic scan_lag_v;
  logic [HW-1:0] best;
  logic [BW-1:0] mode;
  logic [CW-1:0] walk_ptr;
  logic [1:0] walk_lag;
  logic [SW-1:0] wsum;
  logic [CW-1:0] wcnt;
  logic signed [BCW+2:0] lo_bin, hi_bin;
  logic [BCW:0] half_w;

  // Shared restoring divider: quotient replaces numerator bits one per cycle.
  logic [DW-1:0] dv_num, dv_den, dv_rem;
  logic [DCW-1:0] dv_cnt;
  logic [DW:0] dv_trial;

  logic [DispWidth-1:0] pix_bin_full;
  logic hist_hit;
  logic [BW-1:0] hist_addr;
  logic [HW-1:0] hist_wdata;
  logic hist_we;
  logic [BW-1:0] hist_raddr;
  logic [DW-1:0] den_w;
  logic signed [DW:0] den_d;
  logic [DW-1:0] bfc;
  logic [DispWidth+CW-1:0] dinf_wcnt, min_wcnt;
  logic [BfWidth+CW-1:0] bf_wcnt;
  logic [CW-1:0] wcnt_next;
  logic [SW-1:0] wsum_next;
  logic [SW-1:0] wsum_w;
  logic [CW-1:0] wcnt_w;
  logic in_win;
  logic signed [DispWidth+BCW+10:0] dq, loq, hiq;

  assign in_stall = (state != S_LOAD);
  assign cfg_ready = 1'b1;

  assign pix_bin_full = disparity >> 8;
  assign hist_hit = (disparity > FoundThreshold) && (pix_bin_full < NUM_BINS)
                    && (count < CW'(MAX_PIXELS));

  assign dv_trial = {dv_rem, dv_num[DW-1]} - {1'b0, dv_den};

  always_comb begin
    hist_raddr = BW'(disparity >> 8);
    if (state != S_LOAD) hist_raddr = bin_ptr[BW-1:0];
  end

  assign dq = (DispWidth+BCW+11)'(store_q);
  assign loq = (DispWidth+BCW+11)'(lo_bin) <<< 8;
  assign hiq = (DispWidth+BCW+11)'(hi_bin) <<< 8;
  assign in_win = (dq >= loq) && (dq <= hiq);
  assign wsum_next = wsum + SW'(store_q);
  assign wcnt_next = wcnt + CW'(1);

  assign dinf_wcnt = (DispWidth+CW)'(dinf) * (DispWidth+CW)'(wcnt);
  assign min_wcnt = (DispWidth+CW)'(min_mean) * (DispWidth+CW)'(wcnt);
  assign bf_wcnt = (BfWidth+CW)'(bf) * (BfWidth+CW)'(wcnt);
  assign den_d = $signed({1'b0, DW'(wsum)}) - $signed({1'b0, DW'(dinf_wcnt)});
  assign den_w = DW'(25) * DW'(bf) - DW'(512) * DW'(mode);

  // Load-time read-modify-write: bin read in the accept cycle, written in the next cycle.
  logic pend_v;
  logic [BW-1:0] pend_bin;
  logic fwd;
  logic [HW-1:0] hist_cur;
  logic pend_fwd_v;
  logic [HW-1:0] pend_val;
  assign fwd = pend_v && (pend_bin == hist_raddr);
  always_comb begin
    hist_cur = hist_q;
    if (pend_fwd_v) hist_cur = pend_val;
  end

  always_comb begin
    hist_we = 1'b0;
    hist_addr = pend_bin;
    hist_wdata = (hist_cur == HW'(HistMax)) ? hist_cur : hist_cur + HW'(1);
    if (pend_v) hist_we = 1'b1;
    if ((state == S_INIT || state == S_SCAN) && !pend_v) begin
      hist_we = (state == S_INIT) || (bin_ptr < BCW'(NUM_BINS));
      hist_addr = bin_ptr[BW-1:0];
      hist_wdata = '0;
    end
  end

  always_ff @(posedge clk) begin
    hist_q <= hist[hist_raddr];
    if (hist_we) hist[hist_addr] <= hist_wdata;
    store_q <= store[walk_ptr[AW-1:0]];
    if (state == S_LOAD && in_valid && count < CW'(MAX_PIXELS))
      store[count[AW-1:0]] <= disparity;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
      bf <= BfReset;
      dinf <= DinfReset;
      min_mean <= MinMeanReset;
      count <= '0;
      bin_ptr <= '0;
      pend_v <= 1'b0;
      pend_fwd_v <= 1'b0;
      out_valid <= 1'b0;
      scan_lag_v <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          RegBaselineFocal: bf <= cfg_data[BfWidth-1:0];
          RegInfinityDisparity: dinf <= cfg_data[DispWidth-1:0];
          RegMinMeanDisparity: min_mean <= cfg_data[DispWidth-1:0];
          default: ;
        endcase
      end
      pend_v <= 1'b0;
      pend_fwd_v <= 1'b0;
      unique case (state)
        S_INIT: begin
          bin_ptr <= bin_ptr + BCW'(1);
          if (bin_ptr == BCW'(NUM_BINS - 1)) state <= S_LOAD;
        end
        S_LOAD: begin
          if (in_valid) begin
            if (hist_hit) begin
              pend_v <= 1'b1;
              pend_bin <= BW'(pix_bin_full);
              pend_fwd_v <= fwd;
              pend_val <= hist_wdata;
            end
            if (count < CW'(MAX_PIXELS)) count <= count + CW'(1);
            if (last) begin
              state <= S_SCAN;
              bin_ptr <= '0;
              best <= '0;
              mode <= '0;
              scan_lag_v <= 1'b0;
            end
          end
        end
        S_SCAN: begin
          // The last word's bin update lands first; the sweep waits while it is pending.
          if (!pend_v) begin
            // The read of bin k comes back in the next cycle; it is cleared meanwhile.
            scan_lag <= bin_ptr;
            scan_lag_v <= (bin_ptr < BCW'(NUM_BINS));
            if (bin_ptr < BCW'(NUM_BINS)) bin_ptr <= bin_ptr + BCW'(1);
            if (scan_lag_v && hist_q > best) begin
              best <= hist_q;
              mode <= scan_lag[BW-1:0];
            end
            if (!scan_lag_v && bin_ptr == BCW'(NUM_BINS)) state <= S_WDIV0;
          end
        end
        S_WDIV0: begin
          if (best == '0) begin
            distance <= '0;
            mean_disparity <= '0;
            found <= 1'b0;
            above_min <= 1'b0;
            state <= S_OUT;
            out_valid <= 1'b1;
          end else begin
            dv_num <= DW'((2*BW)'(mode) * (2*BW)'(mode)) << 9;
            dv_den <= den_w;
            dv_rem <= '0;
            dv_cnt <= '0;
            state <= (DW'(25) * DW'(bf) <= DW'(512) * DW'(mode)) ? S_WIN : S_WDIV;
            half_w <= (BCW+1)'(NUM_BINS);
            wsum <= '0;
            wcnt <= '0;
            walk_ptr <= '0;
            walk_lag <= '0;
          end
        end
        S_WDIV: begin
          if (!dv_trial[DW]) begin
            dv_rem <= dv_trial[DW-1:0];
            dv_num <= {dv_num[DW-2:0], 1'b1};
          end else begin
            dv_rem <= {dv_rem[DW-2:0], dv_num[DW-1]};
            dv_num <= {dv_num[DW-2:0], 1'b0};
          end
          dv_cnt <= dv_cnt + DCW'(1);
          if (dv_cnt == DCW'(DW - 1)) state <= S_WIN;
        end
        S_WIN: begin
          if (walk_lag == 2'd0) begin
            if (state == S_WIN && half_w == (BCW+1)'(NUM_BINS) && dv_cnt == DCW'(DW)) begin
              if (dv_num < DW'(NUM_BINS))
                half_w <= (dv_num == '0) ? (BCW+1)'(1) : (BCW+1)'(dv_num);
            end
            walk_lag <= 2'd1;
          end else if (walk_lag == 2'd1) begin
            lo_bin <= $signed({3'b0, BCW'(mode)}) - $signed({2'b0, half_w});
            hi_bin <= $signed({3'b0, BCW'(mode)}) + $signed({2'b0, half_w});
            walk_lag <= 2'd2;
          end else if (walk_lag == 2'd2) begin
            walk_ptr <= CW'(1);
            walk_lag <= 2'd3;
            if (count == '0) state <= S_MDIV;
          end else begin
            if (in_win) begin
              wsum <= wsum_next;
              wcnt <= wcnt_next;
            end
            if (walk_ptr == count) begin
              state <= S_MDIV;
            end else begin
              walk_ptr <= walk_ptr + CW'(1);
            end
          end
          if (state == S_WIN && walk_lag == 2'd3 && walk_ptr == count) begin
            dv_num <= DW'(wsum_w);
            dv_den <= DW'(wcnt_w);
            dv_rem <= '0;
            dv_cnt <= '0;
          end else if (walk_lag == 2'd2 && count == '0) begin
            dv_num <= '0;
            dv_den <= '0;
            dv_rem <= '0;
            dv_cnt <= '0;
          end
        end
        S_MDIV: begin
          if (!dv_trial[DW]) begin
            dv_rem <= dv_trial[DW-1:0];
            dv_num <= {dv_num[DW-2:0], 1'b1};
          end else begin
            dv_rem <= {dv_rem[DW-2:0], dv_num[DW-1]};
            dv_num <= {dv_num[DW-2:0], 1'b0};
          end
          dv_cnt <= dv_cnt + DCW'(1);
          if (dv_cnt == DCW'(DW - 1)) state <= S_DDIV0;
        end
        S_DDIV0: begin
          mean_disparity <= (wcnt == '0) ? '0 : dv_num[DispWidth-1:0];
          found <= 1'b1;
          above_min <= (DW'(wsum) >= DW'(min_wcnt));
          dv_num <= bfc;
          dv_den <= DW'(den_d);
          dv_rem <= '0;
          dv_cnt <= '0;
          if (den_d <= 0) begin
            distance <= '1;
            out_valid <= 1'b1;
            state <= S_OUT;
          end else begin
            state <= S_DDIV;
          end
        end
        S_DDIV: begin
          if (!dv_trial[DW]) begin
            dv_rem <= dv_trial[DW-1:0];
            dv_num <= {dv_num[DW-2:0], 1'b1};
          end else begin
            dv_rem <= {dv_rem[DW-2:0], dv_num[DW-1]};
            dv_num <= {dv_num[DW-2:0], 1'b0};
          end
          dv_cnt <= dv_cnt + DCW'(1);
          if (dv_cnt == DCW'(DW - 1)) begin
            state <= S_OUT;
            out_valid <= 1'b1;
            distance <= (dv_trial[DW] ? {dv_num[DW-2:0], 1'b0} : {dv_num[DW-2:0], 1'b1})
                        > DW'(32'hFFFF_FFFF) ? '1 :
                        DistWidth'(dv_trial[DW] ? {dv_num[DW-2:0], 1'b0}
                                                : {dv_num[DW-2:0], 1'b1});
          end
        end
        S_OUT: begin
          if (!out_stall) begin
            out_valid <= 1'b0;
            count <= '0;
            state <= S_LOAD;
          end
        end
        default: state <= S_INIT;
      endcase
    end
  end

  always_comb begin
    wsum_w = in_win ? wsum_next : wsum;
    wcnt_w = in_win ? wcnt_next : wcnt;
  end

  assign bfc = DW'(bf_wcnt) << 16;
endmodule

/* test/roi_disparity_mode_distance_test.sv */
`timescale 1ns / 1ps
module roi_disparity_mode_distance_test;
  import rdmd_pkg::*;

  localparam logic [CfgIdxWidth-1:0] RegUnused = 2'd3;
  localparam int unsigned StoreDepth = MaxPixelsDefault;
  localparam int unsigned BinCount = NumBinsDefault;
  localparam longint unsigned CycleLimit = 3000000;

  typedef struct packed {
    logic [DispWidth-1:0] disparity;
    logic last;
  } pixel_word_t;

  typedef struct packed {
    logic [DistWidth-1:0] distance;
    logic [DispWidth-1:0] mean_disparity;
    logic found;
    logic above_min;
  } range_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [DispWidth-1:0] disparity = '0;
  logic last = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [DistWidth-1:0] distance;
  logic [DispWidth-1:0] mean_disparity;
  logic found;
  logic above_min;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CfgIdxWidth-1:0] cfg_index = '0;
  logic [CfgDataWidth-1:0] cfg_data = '0;

  roi_disparity_mode_distance dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .disparity(disparity), .last(last),
    .out_valid(out_valid), .out_stall(out_stall), .distance(distance),
    .mean_disparity(mean_disparity), .found(found), .above_min(above_min),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // Shadow of the block's registers and region state.
  logic [BfWidth-1:0] bf_reg = BfReset;
  logic [DispWidth-1:0] dinf_reg = DinfReset;
  logic [DispWidth-1:0] min_mean_reg = MinMeanReset;
  logic [DispWidth-1:0] region_pixels [StoreDepth];
  int unsigned bin_counts [BinCount];
  int unsigned region_len = 0;

  pixel_word_t pending_pixels [$];
  range_result_t expected_ranges [$];

  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned hold_left = 0;
  bit hold_go = 1'b0;
  bit in_taken = 1'b0;
  bit cfg_taken = 1'b0;
  int unsigned mismatches = 0;
  longint unsigned cycles = 0;

  function automatic range_result_t estimate_range();
    range_result_t r;
    int unsigned best;
    int unsigned mode;
    longint m, den, w, lo, hi, d, div;
    longint unsigned wsum, wcnt, quot;
    best = 0;
    mode = 0;
    r = '0;
    for (int i = 0; i < BinCount; i++) begin
      if (bin_counts[i] > best) begin
        best = bin_counts[i];
        mode = i;
      end
    end
    if (best == 0) return r;
    m = mode;
    den = 25 * longint'(bf_reg) - 512 * m;
    if (den <= 0) begin
      w = BinCount;
    end else begin
      w = (512 * m * m) / den;
      if (w > BinCount) w = BinCount;
    end
    if (w < 1) w = 1;
    lo = (m - w) * 256;
    hi = (m + w) * 256;
    wsum = 0;
    wcnt = 0;
    for (int i = 0; i < region_len; i++) begin
      d = region_pixels[i];
      if (d >= lo && d <= hi) begin
        wsum += d;
        wcnt++;
      end
    end
    r.found = 1'b1;
    if (wcnt != 0) r.mean_disparity = DispWidth'(wsum / wcnt);
    r.above_min = wsum >= longint'(min_mean_reg) * wcnt;
    div = longint'(wsum) - longint'(dinf_reg) * longint'(wcnt);
    if (div <= 0) begin
      r.distance = '1;
    end else begin
      quot = (longint'(bf_reg) * wcnt * 65536) / div;
      r.distance = quot > 64'hFFFF_FFFF ? '1 : DistWidth'(quot);
    end
    return r;
  endfunction

  task automatic absorb_pixel(input pixel_word_t p);
    int unsigned bin;
    if (region_len < StoreDepth) begin
      region_pixels[region_len] = p.disparity;
      region_len++;
      if (p.disparity > FoundThreshold) begin
        bin = p.disparity >> 8;
        if (bin < BinCount && bin_counts[bin] < HistMax) bin_counts[bin]++;
      end
    end
    if (p.last) begin
      expected_ranges = {expected_ranges, estimate_range()};
      foreach (bin_counts[i]) bin_counts[i] = 0;
      region_len = 0;
    end
  endtask

  initial begin
    forever #5 clk = ~clk;
  end

  // Sampling side: prediction on acceptance, result checks, registers, watchdog.
  always @(posedge clk) begin
    range_result_t want;
    range_result_t got;
    cycles++;
    if (cycles > CycleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
    in_taken = in_valid && !in_stall && !rst;
    cfg_taken = cfg_valid && cfg_ready && !rst;
    if (in_taken) absorb_pixel('{disparity: disparity, last: last});
    if (cfg_taken) begin
      case (cfg_index)
        RegBaselineFocal: bf_reg = cfg_data[BfWidth-1:0];
        RegInfinityDisparity: dinf_reg = cfg_data[DispWidth-1:0];
        RegMinMeanDisparity: min_mean_reg = cfg_data[DispWidth-1:0];
        default: ;
      endcase
    end
    if (out_valid && !out_stall && !rst) begin
      got = '{distance: distance, mean_disparity: mean_disparity,
              found: found, above_min: above_min};
      if (expected_ranges.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", got);
      end else begin
        want = expected_ranges.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("result mismatch: expected %p, got %p", want, got);
        end
      end
    end
  end

  // Long receiver hold-off, counted here.
  always @(posedge clk) begin
    if (hold_go) begin
      hold_left = 2500;
      hold_go = 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
    end
  end

  // Sender: a stalled word stays put until it is taken.
  always @(negedge clk) begin
    pixel_word_t p;
    if (!rst && (!in_valid || in_taken)) begin
      if (pending_pixels.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
        p = pending_pixels.pop_front();
        in_valid <= 1'b1;
        disparity <= p.disparity;
        last <= p.last;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    out_stall <= (hold_left > 0) || ($urandom_range(0, 99) < stall_pct);
  end

  task automatic queue_pixel(input int unsigned value, input bit is_last);
    pixel_word_t p;
    p.disparity = DispWidth'(value);
    p.last = is_last;
    pending_pixels = {pending_pixels, p};
  endtask

  task automatic wait_idle();
    while (pending_pixels.size() > 0 || in_valid || expected_ranges.size() > 0)
      @(posedge clk);
    repeat (600) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxWidth-1:0] idx, input int unsigned value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(negedge clk); while (!cfg_taken);
    cfg_valid <= 1'b0;
  endtask

  // One region: mostly a cluster around a random mode, sometimes noise or low values.
  task automatic queue_region(input int unsigned len);
    int unsigned kind;
    int unsigned center;
    int v;
    kind = $urandom_range(0, 99);
    center = $urandom_range(3, 255);
    for (int unsigned i = 0; i < len; i++) begin
      if (kind < 70) begin
        v = int'(center * 256) + $urandom_range(0, 2047) - 1024;
        if ($urandom_range(0, 9) == 0) v = $urandom_range(0, 65535);
        if (v < 0) v = 0;
        if (v > 65535) v = 65535;
      end else if (kind < 85) begin
        v = $urandom_range(0, 65535);
      end else begin
        v = $urandom_range(0, 520);
      end
      queue_pixel(v, i == len - 1);
    end
  endtask

  task automatic queue_regions(input int unsigned words);
    int unsigned sent;
    int unsigned len;
    sent = 0;
    while (sent < words) begin
      len = ($urandom_range(0, 19) == 0) ? $urandom_range(41, 200) : $urandom_range(1, 40);
      queue_region(len);
      sent += len;
    end
  endtask

  initial begin
    foreach (bin_counts[i]) bin_counts[i] = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed regions with reset settings.
    queue_pixel(0, 1'b1);
    queue_pixel(16'hFFFF, 1'b1);
    queue_pixel(512, 1'b0);
    queue_pixel(513, 1'b1);
    queue_pixel(16'h0A40, 1'b0);
    queue_pixel(16'h0A80, 1'b0);
    queue_pixel(16'h0B00, 1'b0);
    queue_pixel(16'h1400, 1'b1);
    queue_pixel(16'h0300, 1'b0);
    queue_pixel(16'h0500, 1'b0);
    queue_pixel(16'h0A00, 1'b1);
    queue_pixel(16'h0020, 1'b0);
    queue_pixel(16'h0200, 1'b1);
    wait_idle();

    // Window divisor at or below zero everywhere, zero thresholds; receiver held off a while.
    write_reg(RegBaselineFocal, 0);
    write_reg(RegInfinityDisparity, 0);
    write_reg(RegMinMeanDisparity, 0);
    write_reg(RegUnused, 32'hFFFF_FFFF);
    hold_go = 1'b1;
    queue_regions(450);
    wait_idle();

    // Top settings, sender mostly idle.
    idle_pct = 69;
    write_reg(RegBaselineFocal, 20'hFFFFF);
    write_reg(RegInfinityDisparity, 16'hFFFF);
    write_reg(RegMinMeanDisparity, 16'hFFFF);
    queue_regions(450);
    wait_idle();

    // Receiver mostly stalling, random settings.
    idle_pct = 0;
    stall_pct = 69;
    write_reg(RegBaselineFocal, $urandom_range(1, 40000));
    write_reg(RegInfinityDisparity, $urandom_range(0, 1024));
    write_reg(RegMinMeanDisparity, $urandom_range(0, 40000));
    queue_regions(450);
    wait_idle();

    // Both sides idle at times, reset settings.
    idle_pct = 29;
    stall_pct = 29;
    write_reg(RegBaselineFocal, BfReset);
    write_reg(RegInfinityDisparity, DinfReset);
    write_reg(RegMinMeanDisparity, MinMeanReset);
    queue_regions(450);
    wait_idle();

    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule

/* sim.f */
hw/rtl/rdmd_pkg.sv
hw/rtl/roi_disparity_mode_distance.sv
test/roi_disparity_mode_distance_test.sv
